@@ rtl/vta_pkg.sv @@
// ----------------------------------------------------------------------------
// vta_pkg: shared types and constants for the vertex tangent accumulator
// Sizes, function and status codes, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vta_pkg;

  localparam int unsigned VERT_CNT = 2048;
  localparam int unsigned IDX_W    = $clog2(VERT_CNT);
  localparam int unsigned Q_W      = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DVD_W    = 48;
  localparam int unsigned DVS_W    = 36;
  localparam int unsigned SQ_W     = 62;
  localparam int unsigned ROOT_W   = SQ_W / 2;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_FACE = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SKIP = 2'd1,
    STAT_ZERO = 2'd2,
    STAT_SAT  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CAPTURE, OP_LOAD_WR, OP_RD_A, OP_RD_B, OP_RD_C, OP_DELTA,
    OP_DET_MUL, OP_DET_SUB, OP_F_SKIP, OP_NUM_MUL, OP_NUM_SUB, OP_FDIV_PREP,
    OP_DIV_START, OP_F_CLAMP, OP_SUM_RD, OP_SUM_WR, OP_F_END, OP_R_RD,
    OP_R_DOT, OP_R_DSUM, OP_R_DRND, OP_R_ND, OP_R_NDR, OP_R_W, OP_R_ZERO,
    OP_R_SHIFT, OP_R_SQ, OP_R_SQSUM, OP_SQRT_START, OP_RDIV_PREP, OP_R_RES
  } dp_op_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_F_RDA, ST_F_RDB, ST_F_RDC, ST_F_DELTA, ST_F_DETM,
    ST_F_DETS, ST_F_CHK, ST_F_NMUL, ST_F_NSUB, ST_F_DPREP, ST_F_DGO,
    ST_F_DWAIT, ST_F_CLAMP, ST_F_SRD, ST_F_SWR, ST_F_END, ST_R_RD, ST_R_DOT,
    ST_R_DSUM, ST_R_DRND, ST_R_ND, ST_R_NDR, ST_R_W, ST_R_CHK, ST_R_SHIFT,
    ST_R_SQ, ST_R_SQSUM, ST_R_SGO, ST_R_SWAIT, ST_R_DPREP, ST_R_DGO,
    ST_R_DWAIT, ST_R_RES, ST_DONE
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic w_zero;
    logic w_big;
    logic div_done;
    logic sqrt_done;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] pos;
    logic [1:0][Q_W-1:0] tex;
    logic [2:0][Q_W-1:0] nrm;
  } vtx_t;

  typedef logic [2:0][SUM_W-1:0] sum_t;

endpackage

@@ rtl/vta_div.sv @@
// ----------------------------------------------------------------------------
// vta_div: restoring unsigned divider
// One quotient bit per cycle; done pulses as the final step is registered.
// ----------------------------------------------------------------------------
module vta_div import vta_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DVS_W-1:0] rem_q, dvs_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   rem_sh;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_d = DVS_W'(rem_sh - {1'b0, dvs_q});
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DVD_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/vta_sqrt.sv @@
// ----------------------------------------------------------------------------
// vta_sqrt: bit-pair integer square root
// Floor square root, one result bit per cycle; done pulses after the last.
// ----------------------------------------------------------------------------
module vta_sqrt import vta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   val_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned IT_W = $clog2(ROOT_W);

  logic [IT_W-1:0] i_q;
  logic            run_q, done_q;
  logic [SQ_W:0]   v_q, r_q, bit_w, trial;

  assign bit_w = (SQ_W + 1)'(1) << {i_q, 1'b0};
  assign trial = r_q + bit_w;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= IT_W'(ROOT_W - 1);
      end else if (run_q) begin
        i_q <= i_q - 1'b1;
        if (i_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // subtract the trial square where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= {1'b0, val_i};
      r_q <= '0;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_w;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

@@ rtl/vta_dp.sv @@
// ----------------------------------------------------------------------------
// vta_dp: tangent datapath
// Vertex and sum memories, face tangent arithmetic, Gram-Schmidt and
// normalization, with the shared divider and square root units.
// ----------------------------------------------------------------------------
module vta_dp import vta_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic [IDX_W-1:0]       idx_a_i,
  input  logic [IDX_W-1:0]       idx_b_i,
  input  logic [IDX_W-1:0]       idx_c_i,
  input  logic signed [Q_W-1:0]  pos_x_i,
  input  logic signed [Q_W-1:0]  pos_y_i,
  input  logic signed [Q_W-1:0]  pos_z_i,
  input  logic signed [Q_W-1:0]  tex_u_i,
  input  logic signed [Q_W-1:0]  tex_v_i,
  input  logic signed [Q_W-1:0]  norm_x_i,
  input  logic signed [Q_W-1:0]  norm_y_i,
  input  logic signed [Q_W-1:0]  norm_z_i,
  output logic signed [Q_W-1:0]  tan_x_o,
  output logic signed [Q_W-1:0]  tan_y_o,
  output logic signed [Q_W-1:0]  tan_z_o,
  output logic [1:0]             status_o
);

  // round x / 4096 to nearest, ties away from zero
  function automatic logic signed [41:0] rshift12(input logic signed [53:0] x);
    logic [53:0] m;
    logic [53:0] r;
    begin
      m = x[53] ? 54'(-x) : 54'(x);
      r = (m + 54'd2048) >> 12;
      rshift12 = x[53] ? 42'(-r) : 42'(r);
    end
  endfunction

  function automatic logic signed [16:0] sx17(input logic [Q_W-1:0] x);
    sx17 = {x[Q_W-1], x};
  endfunction

  vtx_t vtx_mem [VERT_CNT];
  sum_t sum_mem [VERT_CNT];

  logic [IDX_W-1:0]     idx_a_q, idx_b_q, idx_c_q, corner, vaddr, saddr;
  vtx_t                 ld_q, vrd_q, va_q;
  sum_t                 srd_q, sum_new;
  logic                 sum_ovf;
  logic signed [16:0]   e1_q [3];
  logic signed [16:0]   e2_q [3];
  logic signed [16:0]   du1_q, dv1_q, du2_q, dv2_q;
  logic signed [34:0]   p1_q, p2_q, det_q, num_q;
  logic [34:0]          det_mag, num_mag;
  logic [SUM_W-1:0]     tc_q [3];
  logic                 sat_q;
  logic signed [53:0]   pd_q [3];
  logic signed [49:0]   dsum_q;
  logic signed [37:0]   d_q;
  logic signed [41:0]   ndr_q [3];
  logic signed [42:0]   w_c [3];
  logic [42:0]          wm_q [3];
  logic [2:0]           wneg_q;
  logic [59:0]          sqp_q [3];
  logic [SQ_W-1:0]      sq_q;
  logic [DVD_W-1:0]     dvd_q, quot;
  logic [DVS_W-1:0]     dvs_q;
  logic                 dneg_q;
  logic [DVD_W-1:0]     qneg;
  logic [SUM_W-1:0]     tc_new;
  logic                 tc_ovf;
  logic [Q_W-1:0]       res_q [3];
  status_e              status_q;
  logic [CFG_W-1:0]     min_uv_q;
  logic                 div_done, sqrt_done;
  logic [ROOT_W-1:0]    root;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_uv_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      min_uv_q <= cfg_data_i;
    end
  end

  // address selection
  always_comb begin
    case (cmd_i.k)
      2'd0:    corner = idx_a_q;
      2'd1:    corner = idx_b_q;
      default: corner = idx_c_q;
    endcase
    case (cmd_i.op)
      OP_RD_B: vaddr = idx_b_q;
      OP_RD_C: vaddr = idx_c_q;
      default: vaddr = idx_a_q;
    endcase
    saddr = (cmd_i.op inside {OP_SUM_RD, OP_SUM_WR}) ? corner : idx_a_q;
  end

  // saturating sum update for one corner
  always_comb begin
    logic signed [SUM_W:0] s;
    sum_ovf = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s = (SUM_W + 1)'($signed(srd_q[j])) + (SUM_W + 1)'($signed(tc_q[j]));
      if (s[SUM_W] != s[SUM_W-1]) begin
        sum_ovf    = 1'b1;
        sum_new[j] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_new[j] = s[SUM_W-1:0];
      end
    end
  end

  // magnitudes, clamp of the face quotient, residual vector
  always_comb begin
    det_mag = det_q[34] ? 35'(-det_q) : 35'(det_q);
    num_mag = num_q[34] ? 35'(-num_q) : 35'(num_q);
    qneg    = DVD_W'(-quot);
    tc_ovf  = 1'b0;
    if (!dneg_q && quot > DVD_W'(32'h7FFF_FFFF)) begin
      tc_ovf = 1'b1;
      tc_new = 32'h7FFF_FFFF;
    end else if (dneg_q && quot > DVD_W'(32'h8000_0000)) begin
      tc_ovf = 1'b1;
      tc_new = 32'h8000_0000;
    end else begin
      tc_new = dneg_q ? qneg[SUM_W-1:0] : quot[SUM_W-1:0];
    end
    for (int j = 0; j < 3; j++) begin
      w_c[j] = 43'($signed(srd_q[j])) - 43'(ndr_q[j]);
    end
  end

  // vertex memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD_WR) begin
      vtx_mem[idx_a_q] <= ld_q;
    end
    if (cmd_i.op inside {OP_RD_A, OP_RD_B, OP_RD_C, OP_R_RD}) begin
      vrd_q <= vtx_mem[vaddr];
    end
  end

  // tangent sum memory; load clears the entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD_WR) begin
      sum_mem[saddr] <= '0;
    end else if (cmd_i.op == OP_SUM_WR) begin
      sum_mem[saddr] <= sum_new;
    end
    if (cmd_i.op inside {OP_SUM_RD, OP_R_RD}) begin
      srd_q <= sum_mem[saddr];
    end
  end

  // arithmetic steps
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        idx_a_q  <= idx_a_i;
        idx_b_q  <= idx_b_i;
        idx_c_q  <= idx_c_i;
        ld_q.pos <= {pos_z_i, pos_y_i, pos_x_i};
        ld_q.tex <= {tex_v_i, tex_u_i};
        ld_q.nrm <= {norm_z_i, norm_y_i, norm_x_i};
        for (int j = 0; j < 3; j++) res_q[j] <= '0;
        status_q <= STAT_OK;
        sat_q    <= 1'b0;
      end
      OP_RD_B: va_q <= vrd_q;
      OP_RD_C: begin
        for (int j = 0; j < 3; j++) e1_q[j] <= sx17(vrd_q.pos[j]) - sx17(va_q.pos[j]);
        du1_q <= sx17(vrd_q.tex[0]) - sx17(va_q.tex[0]);
        dv1_q <= sx17(vrd_q.tex[1]) - sx17(va_q.tex[1]);
      end
      OP_DELTA: begin
        for (int j = 0; j < 3; j++) e2_q[j] <= sx17(vrd_q.pos[j]) - sx17(va_q.pos[j]);
        du2_q <= sx17(vrd_q.tex[0]) - sx17(va_q.tex[0]);
        dv2_q <= sx17(vrd_q.tex[1]) - sx17(va_q.tex[1]);
      end
      OP_DET_MUL: begin
        p1_q <= 35'(du1_q) * 35'(dv2_q);
        p2_q <= 35'(du2_q) * 35'(dv1_q);
      end
      OP_DET_SUB: det_q <= p1_q - p2_q;
      OP_F_SKIP:  status_q <= STAT_SKIP;
      OP_NUM_MUL: begin
        p1_q <= 35'(dv2_q) * 35'(e1_q[cmd_i.k]);
        p2_q <= 35'(dv1_q) * 35'(e2_q[cmd_i.k]);
      end
      OP_NUM_SUB: num_q <= p1_q - p2_q;
      OP_FDIV_PREP: begin
        dvd_q  <= {num_mag, 13'b0} + DVD_W'(det_mag);
        dvs_q  <= DVS_W'({det_mag, 1'b0});
        dneg_q <= num_q[34] ^ det_q[34];
      end
      OP_F_CLAMP: begin
        tc_q[cmd_i.k] <= tc_new;
        sat_q         <= sat_q | tc_ovf;
      end
      OP_SUM_WR: sat_q <= sat_q | sum_ovf;
      OP_F_END:  status_q <= sat_q ? STAT_SAT : STAT_OK;
      OP_R_DOT: begin
        for (int j = 0; j < 3; j++) begin
          pd_q[j] <= 54'($signed(vrd_q.nrm[j])) * 54'($signed(srd_q[j]));
        end
      end
      OP_R_DSUM: dsum_q <= 50'(pd_q[0]) + 50'(pd_q[1]) + 50'(pd_q[2]);
      OP_R_DRND: d_q <= 38'(rshift12(54'(dsum_q)));
      OP_R_ND: begin
        for (int j = 0; j < 3; j++) begin
          pd_q[j] <= 54'($signed(vrd_q.nrm[j])) * 54'(d_q);
        end
      end
      OP_R_NDR: begin
        for (int j = 0; j < 3; j++) ndr_q[j] <= rshift12(pd_q[j]);
      end
      OP_R_W: begin
        for (int j = 0; j < 3; j++) begin
          wneg_q[j] <= w_c[j][42];
          wm_q[j]   <= w_c[j][42] ? 43'(-w_c[j]) : 43'(w_c[j]);
        end
      end
      OP_R_ZERO: status_q <= STAT_ZERO;
      OP_R_SHIFT: begin
        for (int j = 0; j < 3; j++) wm_q[j] <= wm_q[j] >> 1;
      end
      OP_R_SQ: begin
        for (int j = 0; j < 3; j++) begin
          sqp_q[j] <= 60'(wm_q[j][29:0]) * 60'(wm_q[j][29:0]);
        end
      end
      OP_R_SQSUM: sq_q <= SQ_W'(sqp_q[0]) + SQ_W'(sqp_q[1]) + SQ_W'(sqp_q[2]);
      OP_RDIV_PREP: begin
        dvd_q  <= DVD_W'({wm_q[cmd_i.k][29:0], 13'b0}) + DVD_W'(root);
        dvs_q  <= DVS_W'({root, 1'b0});
        dneg_q <= wneg_q[cmd_i.k];
      end
      OP_R_RES: res_q[cmd_i.k] <= dneg_q ? qneg[Q_W-1:0] : quot[Q_W-1:0];
      default: ;
    endcase
  end

  vta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_START),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  vta_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT_START),
    .val_i   (sq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // status toward the controller
  always_comb begin
    stat_o.skip      = (det_q == '0) || (det_mag < 35'(min_uv_q));
    stat_o.w_zero    = (wm_q[0] == '0) && (wm_q[1] == '0) && (wm_q[2] == '0);
    stat_o.w_big     = (|wm_q[0][42:30]) || (|wm_q[1][42:30]) || (|wm_q[2][42:30]);
    stat_o.div_done  = div_done;
    stat_o.sqrt_done = sqrt_done;
  end

  assign tan_x_o  = res_q[0];
  assign tan_y_o  = res_q[1];
  assign tan_z_o  = res_q[2];
  assign status_o = status_q;

endmodule

@@ rtl/vta_ctrl.sv @@
// ----------------------------------------------------------------------------
// vta_ctrl: item sequencer
// Steps the datapath through load, face and read work and raises the
// result strobe once per item.
// ----------------------------------------------------------------------------
module vta_ctrl import vta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;

  // state and corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cmd_o.op  = OP_IDLE;
    cmd_o.k   = k_q;
    busy_o    = (state_q != ST_IDLE);
    done_o    = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_CAPTURE;
          k_d      = '0;
          case (func_i)
            FUNC_LOAD: state_d = ST_LOAD;
            FUNC_FACE: state_d = ST_F_RDA;
            FUNC_READ: state_d = ST_R_RD;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD_WR;
        state_d  = ST_DONE;
      end
      // face: fetch corners, form deltas and determinant
      ST_F_RDA:   begin cmd_o.op = OP_RD_A;    state_d = ST_F_RDB;   end
      ST_F_RDB:   begin cmd_o.op = OP_RD_B;    state_d = ST_F_RDC;   end
      ST_F_RDC:   begin cmd_o.op = OP_RD_C;    state_d = ST_F_DELTA; end
      ST_F_DELTA: begin cmd_o.op = OP_DELTA;   state_d = ST_F_DETM;  end
      ST_F_DETM:  begin cmd_o.op = OP_DET_MUL; state_d = ST_F_DETS;  end
      ST_F_DETS:  begin cmd_o.op = OP_DET_SUB; state_d = ST_F_CHK;   end
      ST_F_CHK: begin
        if (stat_i.skip) begin
          cmd_o.op = OP_F_SKIP;
          state_d  = ST_DONE;
        end else begin
          k_d     = '0;
          state_d = ST_F_NMUL;
        end
      end
      // face: one tangent component per pass
      ST_F_NMUL:  begin cmd_o.op = OP_NUM_MUL;   state_d = ST_F_NSUB;  end
      ST_F_NSUB:  begin cmd_o.op = OP_NUM_SUB;   state_d = ST_F_DPREP; end
      ST_F_DPREP: begin cmd_o.op = OP_FDIV_PREP; state_d = ST_F_DGO;   end
      ST_F_DGO:   begin cmd_o.op = OP_DIV_START; state_d = ST_F_DWAIT; end
      ST_F_DWAIT: begin
        if (stat_i.div_done) state_d = ST_F_CLAMP;
      end
      ST_F_CLAMP: begin
        cmd_o.op = OP_F_CLAMP;
        if (k_q == 2'd2) begin
          k_d     = '0;
          state_d = ST_F_SRD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_F_NMUL;
        end
      end
      // face: read-modify-write of each corner's sum
      ST_F_SRD: begin cmd_o.op = OP_SUM_RD; state_d = ST_F_SWR; end
      ST_F_SWR: begin
        cmd_o.op = OP_SUM_WR;
        if (k_q == 2'd2) begin
          k_d     = '0;
          state_d = ST_F_END;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_F_SRD;
        end
      end
      ST_F_END: begin cmd_o.op = OP_F_END; state_d = ST_DONE; end
      // read: project out the normal
      ST_R_RD:   begin cmd_o.op = OP_R_RD;   state_d = ST_R_DOT;  end
      ST_R_DOT:  begin cmd_o.op = OP_R_DOT;  state_d = ST_R_DSUM; end
      ST_R_DSUM: begin cmd_o.op = OP_R_DSUM; state_d = ST_R_DRND; end
      ST_R_DRND: begin cmd_o.op = OP_R_DRND; state_d = ST_R_ND;   end
      ST_R_ND:   begin cmd_o.op = OP_R_ND;   state_d = ST_R_NDR;  end
      ST_R_NDR:  begin cmd_o.op = OP_R_NDR;  state_d = ST_R_W;    end
      ST_R_W:    begin cmd_o.op = OP_R_W;    state_d = ST_R_CHK;  end
      ST_R_CHK: begin
        if (stat_i.w_zero) begin
          cmd_o.op = OP_R_ZERO;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_R_SHIFT;
        end
      end
      // read: scale down until every component is below 2^30
      ST_R_SHIFT: begin
        if (stat_i.w_big) cmd_o.op = OP_R_SHIFT;
        else              state_d  = ST_R_SQ;
      end
      ST_R_SQ:    begin cmd_o.op = OP_R_SQ;       state_d = ST_R_SQSUM; end
      ST_R_SQSUM: begin cmd_o.op = OP_R_SQSUM;    state_d = ST_R_SGO;   end
      ST_R_SGO:   begin cmd_o.op = OP_SQRT_START; state_d = ST_R_SWAIT; end
      ST_R_SWAIT: begin
        if (stat_i.sqrt_done) begin
          k_d     = '0;
          state_d = ST_R_DPREP;
        end
      end
      // read: divide each component by the length
      ST_R_DPREP: begin cmd_o.op = OP_RDIV_PREP; state_d = ST_R_DGO;   end
      ST_R_DGO:   begin cmd_o.op = OP_DIV_START; state_d = ST_R_DWAIT; end
      ST_R_DWAIT: begin
        if (stat_i.div_done) state_d = ST_R_RES;
      end
      ST_R_RES: begin
        cmd_o.op = OP_R_RES;
        if (k_q == 2'd2) begin
          k_d     = '0;
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_R_DPREP;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/vertex_tangent_accumulate_core.sv @@
// From accept to result strobe: load writes one vertex, a skipped face ends early,
// read adds scaling shifts as needed and ends early on a zero result.
// One item at a time: busy stays high until the strobe; the shared divider
// (three divides per face or read) and the root unit set the time per item.
// The result stays on the ports until the next command is accepted.
// Reset clears the sequencer and sets the area threshold to 1; memories keep contents.
// ----------------------------------------------------------------------------
// vertex_tangent_accumulate_core: per-vertex tangent generator
// Loads vertices, accumulates face tangents and returns orthonormalized
// tangents, one command at a time.
// ----------------------------------------------------------------------------
module vertex_tangent_accumulate_core import vta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func_i,
  input  logic [IDX_W-1:0]      idx_a_i,
  input  logic [IDX_W-1:0]      idx_b_i,
  input  logic [IDX_W-1:0]      idx_c_i,
  input  logic signed [Q_W-1:0] pos_x_i,
  input  logic signed [Q_W-1:0] pos_y_i,
  input  logic signed [Q_W-1:0] pos_z_i,
  input  logic signed [Q_W-1:0] tex_u_i,
  input  logic signed [Q_W-1:0] tex_v_i,
  input  logic signed [Q_W-1:0] norm_x_i,
  input  logic signed [Q_W-1:0] norm_y_i,
  input  logic signed [Q_W-1:0] norm_z_i,
  output logic                  done_o,
  output logic signed [Q_W-1:0] tan_x_o,
  output logic signed [Q_W-1:0] tan_y_o,
  output logic signed [Q_W-1:0] tan_z_o,
  output logic [1:0]            status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // threshold writes are always taken
  assign cfg_ready_o = 1'b1;

  vta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  vta_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .idx_a_i    (idx_a_i),
    .idx_b_i    (idx_b_i),
    .idx_c_i    (idx_c_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .tex_u_i    (tex_u_i),
    .tex_v_i    (tex_v_i),
    .norm_x_i   (norm_x_i),
    .norm_y_i   (norm_y_i),
    .norm_z_i   (norm_z_i),
    .tan_x_o    (tan_x_o),
    .tan_y_o    (tan_y_o),
    .tan_z_o    (tan_z_o),
    .status_o   (status_o)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !done_o) |=> busy)
    else $error("busy dropped without a result strobe");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after the result strobe");
`endif

endmodule
